// ----- hdl/sib_pkg.sv -----
// Package for the sorted insertion buffer: depth, widths, status codes,
// command codes, beat structs and the cell-to-cell slot type. No dependencies.
package sib_pkg;

  localparam int DEPTH   = 32;
  localparam int VAL_W   = 32;
  localparam int FILL_W  = 6;
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int IDX_W   = $clog2(DEPTH);

  typedef enum logic {
    CMD_INSERT = 1'b0,
    CMD_DUMP   = 1'b1
  } sib_cmd_t;

  typedef enum logic [1:0] {
    ST_INSERTED = 2'd0,
    ST_DROPPED  = 2'd1,
    ST_ENTRY    = 2'd2,
    ST_EMPTY    = 2'd3
  } sib_status_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_DUMP = 1'b1
  } sib_state_t;

  typedef struct packed {
    logic              command;
    logic signed [VAL_W-1:0] value;
  } sib_in_t;

  typedef struct packed {
    logic [1:0]              status;
    logic signed [VAL_W-1:0] entry;
    logic [FILL_W-1:0]       fill;
    logic                    last;
  } sib_out_t;

  // What one cell shows its neighbors.
  typedef struct packed {
    logic             occ;
    logic [VAL_W-1:0] value;
  } sib_slot_t;

  // Row-wide control broadcast to every cell.
  typedef struct packed {
    logic             ins;
    logic             rot;
    logic [VAL_W-1:0] new_value;
  } sib_ctrl_t;

endpackage

// ----- hdl/sib_cell.sv -----
// One slot of the sorted row: holds a value and an occupied bit, and
// compares, shifts right on insert or rotates left on dump. Uses sib_pkg.
module sib_cell (
  input  logic               clk,
  input  logic               rst,
  input  sib_pkg::sib_ctrl_t ctrl,
  input  sib_pkg::sib_slot_t left,
  input  logic               left_cond,
  input  sib_pkg::sib_slot_t right,
  input  sib_pkg::sib_slot_t head,
  output sib_pkg::sib_slot_t slot,
  output logic               cond
);
  import sib_pkg::*;

  logic             occ;
  logic             occ_next;
  logic [VAL_W-1:0] value;
  logic [VAL_W-1:0] value_next;

  // Flip the sign bit so an unsigned compare orders signed values.
  assign cond = !occ ||
                ({~value[VAL_W-1], value[VAL_W-2:0]} >=
                 {~ctrl.new_value[VAL_W-1], ctrl.new_value[VAL_W-2:0]});

  always_comb begin
    occ_next   = occ;
    value_next = value;
    if (ctrl.ins) begin
      if (left_cond) begin
        occ_next   = left.occ;
        value_next = left.value;
      end else if (cond) begin
        occ_next   = 1'b1;
        value_next = ctrl.new_value;
      end
    end else if (ctrl.rot && occ) begin
      // Last occupied cell wraps around to the head.
      value_next = right.occ ? right.value : head.value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occ <= 1'b0;
    end else begin
      occ <= occ_next;
    end
  end

  always_ff @(posedge clk) begin
    value <= value_next;
  end

  assign slot.occ   = occ;
  assign slot.value = value;

endmodule

// ----- hdl/sorted_insertion_buffer_top.sv -----
// Top level of the sorted insertion buffer: command sequencer, row of
// sib_cell slots and registered result beat. Uses sib_pkg and sib_cell.
//
// An insert does not raise busy: every cell compares against the new value at
// once and the whole row shifts together, so busy stays low and a new
// command may start in the very next cycle; its status beat is registered
// and appears in the cycle after acceptance. A dump rotates the occupied
// cells toward the head once per cycle and emits one entry beat per cycle,
// holding busy high until the last entry beat is issued (no busy for an
// empty store), and leaves the contents in their original order. Results are
// strobed for one cycle each and cannot be stalled by the receiver.
module sorted_insertion_buffer_top (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  sib_pkg::sib_in_t  item,
  output logic              strobe,
  output sib_pkg::sib_out_t result
);
  import sib_pkg::*;

  sib_state_t        state;
  sib_state_t        state_next;
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  count_next;
  logic [IDX_W-1:0]  idx;
  logic [IDX_W-1:0]  idx_next;
  logic              strobe_next;
  sib_out_t          result_next;
  sib_ctrl_t         ctrl;
  logic              accept;
  logic              dump_last;

  sib_slot_t         slots [DEPTH];
  logic              conds [DEPTH];
  logic [DEPTH-1:0]  occ_vec;
  sib_slot_t         empty_slot;

  assign empty_slot.occ   = 1'b0;
  assign empty_slot.value = '0;

  genvar g;
  generate
    for (g = 0; g < DEPTH; g++) begin : g_cell
      sib_cell u_cell (
        .clk       (clk),
        .rst       (rst),
        .ctrl      (ctrl),
        .left      ((g == 0) ? empty_slot : slots[(g == 0) ? 0 : g-1]),
        .left_cond ((g == 0) ? 1'b0 : conds[(g == 0) ? 0 : g-1]),
        .right     ((g == DEPTH-1) ? empty_slot : slots[(g == DEPTH-1) ? g : g+1]),
        .head      (slots[0]),
        .slot      (slots[g]),
        .cond      (conds[g])
      );
      assign occ_vec[g] = slots[g].occ;
    end
  endgenerate

  assign busy      = (state == S_DUMP);
  assign accept    = start && !busy;
  assign dump_last = ({1'b0, idx} + (IDX_W+1)'(1)) == (IDX_W+1)'(count);

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      count  <= '0;
      idx    <= '0;
      strobe <= 1'b0;
    end else begin
      state  <= state_next;
      count  <= count_next;
      idx    <= idx_next;
      strobe <= strobe_next;
    end
  end

  always_ff @(posedge clk) begin
    result <= result_next;
  end

  always_comb begin
    state_next         = state;
    count_next         = count;
    idx_next           = idx;
    strobe_next        = 1'b0;
    result_next        = result;
    ctrl.ins           = 1'b0;
    ctrl.rot           = 1'b0;
    ctrl.new_value     = item.value;
    case (state)
      S_IDLE: begin
        if (accept) begin
          strobe_next        = 1'b1;
          result_next.entry  = '0;
          result_next.last   = 1'b1;
          if (item.command == CMD_INSERT) begin
            if (count == CNT_W'(DEPTH)) begin
              result_next.status = ST_DROPPED;
              result_next.fill   = FILL_W'(count);
            end else begin
              ctrl.ins           = 1'b1;
              count_next         = count + CNT_W'(1);
              result_next.status = ST_INSERTED;
              result_next.fill   = FILL_W'(count_next);
            end
          end else if (count == '0) begin
            result_next.status = ST_EMPTY;
            result_next.fill   = '0;
          end else begin
            // Drop the immediate beat; the dump streams from the S_DUMP state.
            strobe_next = 1'b0;
            idx_next    = '0;
            state_next  = S_DUMP;
          end
        end
      end
      S_DUMP: begin
        strobe_next        = 1'b1;
        result_next.status = ST_ENTRY;
        result_next.entry  = slots[0].value;
        result_next.fill   = FILL_W'(count);
        result_next.last   = dump_last;
        ctrl.rot           = 1'b1;
        idx_next           = idx + IDX_W'(1);
        if (dump_last) begin
          idx_next   = '0;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

`ifndef SYNTH
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("held count beyond depth");

  a_occ_matches_count: assert property (@(posedge clk) disable iff (rst)
    $countones(occ_vec) == int'(count))
    else $error("occupied cells disagree with held count");

  a_dump_nonempty: assert property (@(posedge clk) disable iff (rst)
    busy |-> count != '0)
    else $error("dump running on an empty store");

  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    (accept && item.command == CMD_INSERT && count != CNT_W'(DEPTH))
      |=> count == $past(count) + CNT_W'(1))
    else $error("accepted insert did not grow the store");

  a_dump_ends: assert property (@(posedge clk) disable iff (rst)
    (busy && dump_last) |=> (!busy && strobe && result.last))
    else $error("dump did not end with a last beat");
`endif

endmodule
